// ===== hw/rtl/ros_pkg.sv =====
package ros_pkg;

    localparam int COORD_W = 16;
    localparam int EXT_W   = COORD_W + 1;
    localparam int IDX_IN_W = 4;

    // command codes of an input item
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef logic signed [EXT_W-1:0]   coord_t;
    typedef logic signed [COORD_W-1:0] field_t;

    // one queued operation
    // write: a = x, b = y, c = x + w, d = y + h
    // query: a = left, b = top, c = right, d = bottom
    typedef struct packed {
        logic [1:0]          cmd;
        logic [IDX_IN_W-1:0] idx;
        field_t              field;
        coord_t              a;
        coord_t              b;
        coord_t              c;
        coord_t              d;
    } op_t;

    // one stored region, edges precomputed
    typedef struct packed {
        field_t field;
        coord_t x;
        coord_t y;
        coord_t xr;
        coord_t yb;
    } entry_t;

endpackage

// ===== hw/rtl/ros_front.sv =====
module ros_front
    import ros_pkg::*;
#(
    parameter int ENTRY_COUNT = 16
)
(
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [IDX_IN_W-1:0] entry_index,
    input  logic signed [15:0]  field_id,
    input  logic signed [15:0]  pos_x,
    input  logic signed [15:0]  pos_y,
    input  logic signed [15:0]  size_w,
    input  logic signed [15:0]  size_h,
    input  logic signed [15:0]  bound_left,
    input  logic signed [15:0]  bound_right,
    input  logic signed [15:0]  bound_top,
    input  logic signed [15:0]  bound_bottom,
    input  logic                facing_mirrored,
    input  logic                q_full,
    output logic                q_push,
    output op_t                 q_op
);

    coord_t     px;
    coord_t     py;
    coord_t     bl;
    coord_t     br;
    coord_t     bt;
    coord_t     bb;
    logic       range_ok;
    logic       keep;

    always_comb
    begin
        px = {pos_x[15], pos_x};
        py = {pos_y[15], pos_y};
        bl = {bound_left[15], bound_left};
        br = {bound_right[15], bound_right};
        bt = {bound_top[15], bound_top};
        bb = {bound_bottom[15], bound_bottom};

        range_ok = {3'b000, entry_index} < 7'(ENTRY_COUNT);

        q_op       = '0;
        q_op.cmd   = command;
        q_op.idx   = entry_index;
        q_op.field = field_id;

        unique case (command) inside
            CMD_QUERY:
            begin
                // mirrored facing swaps and negates the horizontal offsets
                if (facing_mirrored)
                begin
                    q_op.a = px - br;
                    q_op.c = px - bl;
                end
                else
                begin
                    q_op.a = px + bl;
                    q_op.c = px + br;
                end
                q_op.b = py + bt;
                q_op.d = py + bb;
                keep   = 1'b1;
            end
            CMD_WRITE, CMD_CLEAR:
            begin
                q_op.a = px;
                q_op.b = py;
                q_op.c = px + {size_w[15], size_w};
                q_op.d = py + {size_h[15], size_h};
                keep   = range_ok;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase

        in_ready = !q_full;
        q_push   = in_valid && !q_full && keep;
    end

endmodule

// ===== hw/rtl/ros_queue.sv =====
module ros_queue
    import ros_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    output logic pop_valid,
    input  logic pop,
    output op_t  pop_op
);

    op_t        slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;

    always_comb
    begin
        full       = count_reg == 2'd2;
        pop_valid  = count_reg != 2'd0;
        pop_op     = slot_reg[rd_ptr_reg];
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

// ===== hw/rtl/ros_back.sv =====
module ros_back
    import ros_pkg::*;
#(
    parameter int ENTRY_COUNT = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  field_t current_field,
    input  logic   q_valid,
    input  op_t    q_op,
    output logic   q_pop,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   hit,
    output field_t hit_field
);

    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    entry_t                 mem [ENTRY_COUNT];
    entry_t                 rd_data_reg;
    entry_t                 wr_entry;
    logic [ENTRY_COUNT-1:0] active_reg;
    logic                   state_reg;
    logic                   state_next;
    logic [CNT_W-1:0]       rd_cnt_reg;
    logic [CNT_W-1:0]       rd_cnt_next;
    logic                   chk_valid_reg;
    logic [IDX_W-1:0]       chk_idx_reg;
    op_t                    query_reg;
    logic                   out_valid_reg;
    logic                   hit_reg;
    field_t                 hit_field_reg;
    logic [6:0]             idx_wide;
    logic [IDX_W-1:0]       waddr;
    logic [IDX_W-1:0]       rd_addr;
    logic                   head_is_query;
    logic                   out_free;
    logic                   wr_en;
    logic                   clr_en;
    logic                   issue;
    logic                   match;
    logic                   finish;

    always_comb
    begin
        idx_wide      = {3'b000, q_op.idx};
        waddr         = idx_wide[IDX_W-1:0];
        rd_addr       = rd_cnt_reg[IDX_W-1:0];
        head_is_query = q_op.cmd == CMD_QUERY;
        out_free      = !out_valid_reg || out_ready;

        q_pop  = (state_reg == ST_IDLE) && q_valid && (!head_is_query || out_free);
        wr_en  = q_pop && (q_op.cmd == CMD_WRITE);
        clr_en = q_pop && (q_op.cmd == CMD_CLEAR);

        wr_entry.field = q_op.field;
        wr_entry.x     = q_op.a;
        wr_entry.y     = q_op.b;
        wr_entry.xr    = q_op.c;
        wr_entry.yb    = q_op.d;

        issue = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_W'(ENTRY_COUNT));

        // touching edges count as overlap
        match = chk_valid_reg && active_reg[chk_idx_reg]
             && (rd_data_reg.field == current_field)
             && (query_reg.a <= rd_data_reg.xr)
             && (query_reg.b <= rd_data_reg.yb)
             && (rd_data_reg.x <= query_reg.c)
             && (rd_data_reg.y <= query_reg.d);
        finish = chk_valid_reg && (match || (chk_idx_reg == LAST_IDX));

        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && head_is_query)
                begin
                    state_next  = ST_SCAN;
                    rd_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid = out_valid_reg;
        hit       = hit_reg;
        hit_field = hit_field_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            chk_valid_reg <= 1'b0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            chk_valid_reg <= issue && !finish;
            if (wr_en)
            begin
                active_reg[waddr] <= 1'b1;
            end
            if (clr_en)
            begin
                active_reg[waddr] <= 1'b0;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // region table, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wr_entry;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= rd_addr;
        if (q_pop && head_is_query)
        begin
            query_reg <= q_op;
        end
        if (finish)
        begin
            hit_reg       <= match;
            hit_field_reg <= match ? rd_data_reg.field : '0;
        end
    end

    a_finish_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!out_valid_reg || out_ready))
        else $error("result overwrites an untaken result");

    a_no_pop_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !q_pop)
        else $error("queue popped during scan");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (hit_field_reg == '0))
        else $error("miss result carries a field id");

endmodule

// ===== hw/rtl/region_overlap_search_core.sv =====
// region overlap search: a table of ENTRY_COUNT rectangles (field id, x, y,
// width, height, active mark) and a first-hit overlap search. command 0 writes
// an entry and marks it active, command 1 clears its mark, command 2 builds an
// actor box from a position and four signed offsets (horizontal offsets
// mirrored when facing_mirrored is set) and returns one item: hit and the
// field id of the lowest-index active entry whose field id equals
// current_field and whose rectangle overlaps the box, touching edges included;
// a miss returns hit 0 and hit_field 0. writes, clears and command 3 return
// nothing. the front end accepts an item per cycle into a two-deep queue,
// while the queue is not full, and precomputes the box or the entry's right
// and bottom edges; the back end executes. a query scans the region table
// through its single read port, one entry per cycle, in index order, and
// ends early at the first hit. active marks clear at reset, there is no
// clearing pass. the user must see that current_field is written only while
// the block is idle; the block itself does not enforce it.
module region_overlap_search_core
    import ros_pkg::*;
#(
    parameter int ENTRY_COUNT = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_write_en,
    input  logic signed [15:0]  cfg_write_data,
    // input items
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [3:0]          entry_index,
    input  logic signed [15:0]  field_id,
    input  logic signed [15:0]  pos_x,
    input  logic signed [15:0]  pos_y,
    input  logic signed [15:0]  size_w,
    input  logic signed [15:0]  size_h,
    input  logic signed [15:0]  bound_left,
    input  logic signed [15:0]  bound_right,
    input  logic signed [15:0]  bound_top,
    input  logic signed [15:0]  bound_bottom,
    input  logic                facing_mirrored,
    // result items
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic signed [15:0]  hit_field
);

    // current field register
    field_t current_field_reg;

    // front to queue
    logic   push;
    op_t    push_op;
    logic   q_full;

    // queue to back end
    logic   q_valid;
    logic   q_pop;
    op_t    q_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_field_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            current_field_reg <= cfg_write_data;
        end
    end

    // accept, drop unused commands and out-of-table writes and clears, precompute edges
    ros_front #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .entry_index     (entry_index),
        .field_id        (field_id),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .size_w          (size_w),
        .size_h          (size_h),
        .bound_left      (bound_left),
        .bound_right     (bound_right),
        .bound_top       (bound_top),
        .bound_bottom    (bound_bottom),
        .facing_mirrored (facing_mirrored),
        .q_full          (q_full),
        .q_push          (push),
        .q_op            (push_op)
    );

    // two-deep queue decouples intake from the scan
    ros_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_op    (q_op)
    );

    // table writes, in-order scan and result register
    ros_back #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .current_field (current_field_reg),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .hit_field     (hit_field)
    );

endmodule
